// ===== rtl/indexed_min_heap_queue_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the indexed min-heap queue unit
// ---------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// property holds unless reset is high
`define IMHQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define IMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/imhq_pkg.sv =====
// ---------------------------------------------------------------------------
// imhq_pkg
// Types and constants for the indexed min-heap queue unit.
// ---------------------------------------------------------------------------
package imhq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned NODE_W       = 10;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned LIMIT_W      = 11;
  localparam int unsigned COUNT_W      = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node_id;
    logic [KEY_W-1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  popped_node;
    logic               popped_valid;
    status_t            status;
    logic [COUNT_W-1:0] entries_now;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,     // read parent
    S_UP_CMP,    // compare with parent, swap
    S_POP_RD,    // read last entry
    S_POP_WR,    // move last to root
    S_DN_RDL,    // read left child
    S_DN_RDR,    // read right child
    S_DN_CMP,    // pick smallest, swap
    S_OUT
  } state_t;

endpackage

// ===== rtl/indexed_min_heap_queue_unit.sv =====
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Binary min-heap of node ids keyed by unsigned 16.16 priority, with slot map.
// ---------------------------------------------------------------------------
// One transaction is taken at a time; in_ready is low until its result has
// been taken. A push writes the new entry at the end of the heap and then
// climbs one level per parent read and compare; it goes straight to output
// when it is dropped or lands in an empty heap. A pop reads the root, moves
// the last entry to the root and then descends, reading the left and the
// right child and comparing, until it stops or reaches a leaf; a pop on an
// empty heap goes straight to output. The pace is set by the heap memory,
// which has one write port and one registered read port: every sift step
// reads one entry per cycle and one comparator decides each step. After
// reset the slot map is cleared one entry a cycle while in_ready stays low.
`include "indexed_min_heap_queue_unit_defines.svh"

module indexed_min_heap_queue_unit #(
  parameter int unsigned CAPACITY = imhq_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  imhq_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output imhq_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [imhq_pkg::LIMIT_W-1:0] cfg_wdata
);
  import imhq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);   // count width
  localparam int unsigned SW = CW;                     // slot width incl. invalid
  localparam int unsigned NN = 1 << NODE_W;
  localparam int unsigned LW = (CW >= LIMIT_W) ? CW + 1 : LIMIT_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // heap memory: node and key together
  logic [NODE_W+KEY_W-1:0] heap_mem [CAPACITY];
  logic [SW-1:0]           slot_mem [NN];

  state_t state, state_next;
  logic [CW-1:0]     entry_count;
  logic [LIMIT_W-1:0] capacity_limit;
  logic [AW-1:0]     cur;           // current slot of the moving entry
  logic [NODE_W-1:0] cur_node;
  logic [KEY_W-1:0]  cur_key;
  logic [AW-1:0]     best_idx;
  logic [NODE_W-1:0] best_node;
  logic [KEY_W-1:0]  best_key;
  logic              best_child;    // left child beats the current entry
  logic [NODE_W+KEY_W-1:0] rd_data;
  out_item_t         res;
  logic              clearing;
  logic [NODE_W-1:0] clr_idx;

  // memory port control
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [NODE_W+KEY_W-1:0] mem_wdata;
  logic              slot_we;
  logic [NODE_W-1:0] slot_waddr;
  logic [SW-1:0]     slot_wdata;
  logic              mem_we2;       // second write for a swap, next cycle
  logic [AW-1:0]     w2_addr;
  logic [NODE_W+KEY_W-1:0] w2_data;
  logic              s2_we;
  logic [NODE_W-1:0] s2_addr;
  logic [SW-1:0]     s2_data;

  // compare unit, shared by every sift step
  logic              cmp_less;
  logic [KEY_W-1:0]  cmp_a, cmp_b;
  assign cmp_less = cmp_a < cmp_b;

  logic [CW:0]       lim_eff;
  logic [CW+1:0]     left_w;
  logic [AW-1:0]     parent;
  logic              push_in, pop_in;
  logic              right_ok;      // right child lies inside the heap
  logic              dn_right;      // right child is the smallest
  logic              dn_swap;
  logic [AW-1:0]     dn_idx;
  logic [NODE_W+KEY_W-1:0] dn_data;

  assign in_ready  = (state == S_IDLE) && !clearing && !mem_we2;
  assign out_valid = (state == S_OUT);
  assign out_data  = res;
  assign parent    = AW'((cur - AW'(1)) >> 1);
  assign left_w    = (CW+2)'({cur, 1'b1});
  assign lim_eff   = (LW'(capacity_limit) > LW'(CAPACITY))
                     ? (CW+1)'(CAPACITY) : (CW+1)'(capacity_limit);
  assign push_in   = in_valid && in_ready && (in_data.cmd == CMD_PUSH);
  assign pop_in    = in_valid && in_ready && (in_data.cmd == CMD_POP);
  assign right_ok  = (left_w + (CW+2)'(1)) < (CW+2)'(entry_count);
  assign dn_right  = right_ok && cmp_less;
  assign dn_swap   = (state == S_DN_CMP) && (dn_right || best_child);
  assign dn_idx    = dn_right ? AW'(left_w + (CW+2)'(1)) : best_idx;
  assign dn_data   = dn_right ? rd_data : {best_node, best_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity_limit <= LIMIT_W'(1024);
      clearing       <= 1'b1;
      clr_idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) capacity_limit <= cfg_wdata;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (&clr_idx) clearing <= 1'b0;
      end
    end
  end

  // second-half-of-swap register (ignored except for one cycle)
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_we2 <= 1'b0;
      s2_we   <= 1'b0;
    end else begin
      mem_we2 <= 1'b0;
      s2_we   <= 1'b0;
      if (state == S_UP_CMP && cmp_less) begin
        mem_we2 <= 1'b1;
        s2_we   <= 1'b1;
      end
      if (dn_swap) begin
        mem_we2 <= 1'b1;
        s2_we   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UP_CMP) begin
      w2_addr <= parent;
      w2_data <= {cur_node, cur_key};
      s2_addr <= cur_node;
      s2_data <= SW'(parent);
    end else begin
      w2_addr <= dn_idx;
      w2_data <= {cur_node, cur_key};
      s2_addr <= cur_node;
      s2_data <= SW'(dn_idx);
    end
  end

  // heap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we2) heap_mem[w2_addr] <= w2_data;
    else if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
    rd_data <= heap_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (clearing) slot_mem[clr_idx] <= CAP;
    else if (s2_we) slot_mem[s2_addr] <= s2_data;
    else if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      if (push_in && ({1'b0, entry_count} < lim_eff)) entry_count <= entry_count + 1'b1;
      if (pop_in && entry_count != '0) entry_count <= entry_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur      <= AW'(entry_count);
      cur_node <= in_data.node_id;
      cur_key  <= in_data.priority_req;
      res.popped_node  <= '0;
      res.popped_valid <= 1'b0;
      res.status       <= ST_DONE;
      if (in_data.cmd == CMD_PUSH) begin
        if (!({1'b0, entry_count} < lim_eff)) res.status <= ST_FULL;
        res.entries_now <= ({1'b0, entry_count} < lim_eff)
                           ? COUNT_W'(entry_count + 1'b1) : COUNT_W'(entry_count);
      end else begin
        if (entry_count == '0) begin
          res.status      <= ST_EMPTY;
          res.entries_now <= '0;
        end else begin
          res.entries_now <= COUNT_W'(entry_count - 1'b1);
        end
      end
    end
    case (state)
      S_UP_CMP: if (cmp_less) cur <= parent;
      S_POP_RD: begin
        res.popped_node  <= rd_data[KEY_W +: NODE_W];
        res.popped_valid <= 1'b1;
        cur              <= '0;
      end
      S_POP_WR: begin
        cur_node <= rd_data[KEY_W +: NODE_W];
        cur_key  <= rd_data[KEY_W-1:0];
      end
      S_DN_RDR: begin
        best_idx   <= AW'(left_w);
        best_node  <= rd_data[KEY_W +: NODE_W];
        best_key   <= rd_data[KEY_W-1:0];
        best_child <= cmp_less;
      end
      S_DN_CMP: if (dn_swap) cur <= dn_idx;
      default: ;
    endcase
  end

  // comparator operands
  always_comb begin
    cmp_a = cur_key;
    cmp_b = rd_data[KEY_W-1:0];
    case (state)
      S_DN_RDR: begin
        // left child against the moving entry
        cmp_a = rd_data[KEY_W-1:0];
        cmp_b = cur_key;
      end
      S_DN_CMP: begin
        // right child against the smaller of the two so far
        cmp_a = rd_data[KEY_W-1:0];
        cmp_b = best_child ? best_key : cur_key;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur;
    mem_wdata  = {cur_node, cur_key};
    mem_raddr  = cur;
    slot_we    = 1'b0;
    slot_waddr = cur_node;
    slot_wdata = SW'(cur);
    unique case (state)
      S_IDLE: begin
        mem_raddr = '0;
        if (push_in) begin
          mem_we     = ({1'b0, entry_count} < lim_eff);
          mem_waddr  = AW'(entry_count);
          mem_wdata  = {in_data.node_id, in_data.priority_req};
          slot_we    = mem_we;
          slot_waddr = in_data.node_id;
          slot_wdata = SW'(entry_count);
          state_next = !mem_we ? S_OUT : (entry_count == '0) ? S_OUT : S_UP_RD;
        end else if (pop_in) begin
          state_next = (entry_count == '0) ? S_OUT : S_POP_RD;
        end
      end
      S_UP_RD: begin
        mem_raddr  = parent;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        // child < parent: parent entry drops to cur, cur entry goes up next cycle
        if (cmp_less) begin
          mem_we     = 1'b1;
          mem_wdata  = rd_data;
          slot_we    = 1'b1;
          slot_waddr = rd_data[KEY_W +: NODE_W];
          state_next = (parent == '0) ? S_OUT : S_UP_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_POP_RD: begin
        // rd_data holds the root; fetch the last entry
        slot_we    = 1'b1;
        slot_waddr = rd_data[KEY_W +: NODE_W];
        slot_wdata = CAP;
        mem_raddr  = AW'(entry_count);
        state_next = (entry_count == '0) ? S_OUT : S_POP_WR;
      end
      S_POP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = rd_data;
        slot_we    = 1'b1;
        slot_waddr = rd_data[KEY_W +: NODE_W];
        slot_wdata = '0;
        state_next = S_DN_RDL;
      end
      S_DN_RDL: begin
        // issue read of left child; result arrives next state
        mem_raddr  = AW'(left_w);
        state_next = (left_w < (CW+2)'(entry_count)) ? S_DN_RDR : S_OUT;
      end
      S_DN_RDR: begin
        // rd_data = left child; fetch the right one
        mem_raddr  = AW'(left_w + (CW+2)'(1));
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        // smaller child moves up to cur, cur entry goes down next cycle
        if (dn_swap) begin
          mem_we     = 1'b1;
          mem_wdata  = dn_data;
          slot_we    = 1'b1;
          slot_waddr = dn_data[KEY_W +: NODE_W];
          state_next = S_DN_RDL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  `IMHQ_ASSERT(a_not_ready_busy, clk, rst, !(in_ready && out_valid), "ready while result held")
  `IMHQ_ASSERT(a_count_cap, clk, rst, entry_count <= CAP, "entry count above capacity")
  `IMHQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `IMHQ_ASSERT(a_clear_idle, clk, rst, !(clearing && state != S_IDLE), "work during clear")

endmodule
